// ===== hdl/bfar_pkg.sv =====
// bfar_pkg: types and constants for the block framer with acknowledge and retry
// holds the input and result beat structs, the phase enum and the protocol characters
// no dependencies
`timescale 1ns / 1ps

package bfar_pkg;

  // input beat codes
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_SLOT  = 2'd1;
  localparam logic [1:0] MODE_REPLY = 2'd2;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // block outcomes
  localparam logic [1:0] OUT_ACCEPTED  = 2'd0;
  localparam logic [1:0] OUT_CANCELLED = 2'd1;
  localparam logic [1:0] OUT_ESCAPED   = 2'd2;
  localparam logic [1:0] OUT_EXHAUSTED = 2'd3;

  // line characters
  localparam logic [7:0] CH_STX     = 8'h02;
  localparam logic [7:0] CH_ETX     = 8'h03;
  localparam logic [7:0] CH_ACK     = 8'h06;
  localparam logic [7:0] CH_CAN     = 8'h18;
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] REPLY_MASK = 8'h7f;

  // configuration register indexes
  localparam logic CFG_BINARY_MODE = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
  localparam logic [3:0] TRIES_MAX         = 4'd15;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_SENDING  = 2'd1,
    PH_AWAITING = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] outcome;
  } out_item_t;

endpackage

// ===== hdl/block_framer_with_ack_retry.sv =====
// block_framer_with_ack_retry: stop-and-wait block sender with xor checksum and retry
// buffers one block, frames it on transmit slots and resolves it on the reply byte
// depends on bfar_pkg
`timescale 1ns / 1ps

// Takes one input beat a cycle unless the output stalls. Data beats fill a block buffer
// of BLOCK_SIZE bytes (newline becomes carriage return unless binary_mode is set); the
// block closes on end_of_block or when full. Each transmit slot beat then yields one
// frame byte (STX, count high, count low, data, ETX, xor checksum), and a reply beat
// yields an outcome report or restarts the frame, up to retry_limit transmissions. Beats
// that arrive in the wrong phase, and mode 3, are taken and dropped. A result is
// registered when its beat is accepted; the buffer has one write and one registered read
// port, and each beat uses at most one of them, which keeps the rate at one beat a cycle.
// No clearing pass is needed after reset. Write configuration only while the block is idle.
module block_framer_with_ack_retry
  import bfar_pkg::*;
#(
  parameter int BLOCK_SIZE = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int CNT_W  = $clog2(BLOCK_SIZE + 1);
  localparam int POS_W  = $clog2(BLOCK_SIZE + 5);
  localparam int ADDR_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  // configuration
  logic       binary_mode_q;
  logic [3:0] retry_limit_q;

  // block state
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [7:0]         xor_q, xor_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [3:0]         tries_q, tries_d;

  // block buffer
  logic [7:0]        mem [BLOCK_SIZE];
  logic [7:0]        mem_rd_q;
  logic              wr_en, rd_en;
  logic [7:0]        wr_byte;
  logic [ADDR_W-1:0] rd_addr;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       kind_q;
  logic [7:0] tx_q;
  logic [1:0] outcome_q;
  logic       sel_mem_q;

  // result of the current beat
  logic       res_valid;
  logic       res_kind;
  logic [7:0] res_tx;
  logic [1:0] res_outcome;
  logic       res_sel_mem;

  logic             accept;
  logic [POS_W-1:0] fill_pos;
  logic [POS_W-1:0] data_idx;
  logic [15:0]      fill_wide;
  logic [7:0]       reply;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_pos   = POS_W'(fill_q);
  assign data_idx   = pos_q - POS_W'(3);
  assign rd_addr    = data_idx[ADDR_W-1:0];
  assign fill_wide  = 16'(fill_q);
  assign reply      = in_item_i.data_byte & REPLY_MASK;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= 1'b0;
      retry_limit_q <= RETRY_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BINARY_MODE: binary_mode_q <= cfg_data_i[0];
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state of the block
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    xor_d   = xor_q;
    pos_d   = pos_q;
    tries_d = tries_q;
    wr_en   = 1'b0;
    wr_byte = in_item_i.data_byte;
    if (!binary_mode_q && in_item_i.data_byte == CH_LF) begin
      wr_byte = CH_CR;
    end
    if (accept) begin
      case (in_item_i.mode)
        MODE_DATA: begin
          if (phase_q == PH_LOADING) begin
            if (fill_q < CNT_W'(BLOCK_SIZE)) begin
              wr_en  = 1'b1;
              xor_d  = xor_q ^ wr_byte;
              fill_d = fill_q + CNT_W'(1);
            end
            if (in_item_i.end_of_block || fill_d >= CNT_W'(BLOCK_SIZE)) begin
              phase_d = PH_SENDING;
              pos_d   = '0;
              tries_d = '0;
            end
          end
        end
        MODE_SLOT: begin
          if (phase_q == PH_SENDING) begin
            if (pos_q >= fill_pos + POS_W'(4)) begin
              phase_d = PH_AWAITING;
              pos_d   = '0;
              if (tries_q < TRIES_MAX) begin
                tries_d = tries_q + 4'd1;
              end
            end else begin
              pos_d = pos_q + POS_W'(1);
            end
          end
        end
        MODE_REPLY: begin
          if (phase_q == PH_AWAITING) begin
            if (reply == CH_ACK || reply == CH_CAN || reply == CH_ESC
                || tries_q >= retry_limit_q) begin
              phase_d = PH_LOADING;
              fill_d  = '0;
              xor_d   = '0;
              pos_d   = '0;
              tries_d = '0;
            end else begin
              phase_d = PH_SENDING;
              pos_d   = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result of the accepted beat
  always_comb begin
    res_valid   = 1'b0;
    res_kind    = KIND_BYTE;
    res_tx      = '0;
    res_outcome = OUT_ACCEPTED;
    res_sel_mem = 1'b0;
    rd_en       = 1'b0;
    case (in_item_i.mode)
      MODE_SLOT: begin
        if (phase_q == PH_SENDING) begin
          res_valid = 1'b1;
          if (pos_q == POS_W'(0)) begin
            res_tx = CH_STX;
          end else if (pos_q == POS_W'(1)) begin
            res_tx = fill_wide[15:8];
          end else if (pos_q == POS_W'(2)) begin
            res_tx = fill_wide[7:0];
          end else if (pos_q < fill_pos + POS_W'(3)) begin
            res_sel_mem = 1'b1;
            rd_en       = accept;
          end else if (pos_q == fill_pos + POS_W'(3)) begin
            res_tx = CH_ETX;
          end else begin
            res_tx = xor_q;
          end
        end
      end
      MODE_REPLY: begin
        if (phase_q == PH_AWAITING) begin
          res_kind = KIND_REPORT;
          if (reply == CH_ACK) begin
            res_valid   = 1'b1;
            res_outcome = OUT_ACCEPTED;
          end else if (reply == CH_CAN) begin
            res_valid   = 1'b1;
            res_outcome = OUT_CANCELLED;
          end else if (reply == CH_ESC) begin
            res_valid   = 1'b1;
            res_outcome = OUT_ESCAPED;
          end else if (tries_q >= retry_limit_q) begin
            res_valid   = 1'b1;
            res_outcome = OUT_EXHAUSTED;
          end
        end
      end
      default: ;
    endcase
  end

  // output valid: load on a beat, clear when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOADING;
      fill_q      <= '0;
      xor_q       <= '0;
      pos_q       <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      xor_q       <= xor_d;
      pos_q       <= pos_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q    <= res_kind;
      tx_q      <= res_tx;
      outcome_q <= res_outcome;
      sel_mem_q <= res_sel_mem;
    end
  end

  // block buffer write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[ADDR_W-1:0]] <= wr_byte;
    end
  end

  // block buffer registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_item_o.kind    = kind_q;
  assign out_item_o.tx_byte = sel_mem_q ? mem_rd_q : tx_q;
  assign out_item_o.outcome = outcome_q;

endmodule

// ===== tb/tb_block_framer_with_ack_retry.sv =====
// tb_block_framer_with_ack_retry: self-checking bench for the stop-and-wait block framer
// queue-fed beat driver, result monitor with a built-in framer predictor, watchdog
// depends on bfar_pkg and block_framer_with_ack_retry
`timescale 1ns / 1ps

module tb_block_framer_with_ack_retry;
  import bfar_pkg::*;

  localparam int BLOCK_SIZE    = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_AT_BEAT  = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 90;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // register settings per stimulus phase, phase 0 keeps the reset values
  localparam logic [5:0]  BIN_PLAN   = 6'b101010;
  localparam logic [23:0] LIMIT_PLAN = {4'd2, 4'd15, 4'd0, 4'd1, 4'd15, 4'd3};

  typedef enum logic [1:0] {
    OP_BEAT,
    OP_CFG,
    OP_DRAIN
  } pend_op_e;

  typedef struct packed {
    pend_op_e   op;
    in_item_t   beat;
    logic       cfg_idx;
    logic [3:0] cfg_val;
  } pend_entry_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_idx_i   = CFG_BINARY_MODE;
  logic [3:0] cfg_data_i = 4'd0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  block_framer_with_ack_retry #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // predicted framer state
  logic [7:0] fr_store [BLOCK_SIZE];
  int         fr_fill        = 0;
  logic [7:0] fr_xsum        = 8'h00;
  phase_e     fr_phase       = PH_LOADING;
  int         fr_pos         = 0;
  logic [3:0] fr_tries       = 4'd0;
  logic       fr_binary      = 1'b0;
  logic [3:0] fr_retry_limit = RETRY_LIMIT_RESET;

  out_item_t   framer_out_q [$];
  pend_entry_t pend [$];

  // generator-side view of the retry limit
  logic [3:0] gen_retry_limit = RETRY_LIMIT_RESET;
  int         real_items      = 0;

  int  cycles       = 0;
  int  idle_cycles  = 0;
  int  beats_taken  = 0;
  int  mismatches   = 0;
  bit  beat_taken   = 1'b0;
  bit  run_done     = 1'b0;
  int  send_gap     = 0;
  int  settle_cnt   = 0;
  int  rx_gap       = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;

  // advance the predicted framer by one accepted beat
  function automatic void framer_predict(input in_item_t it, output bit has,
                                         output out_item_t res);
    int         pos;
    logic [7:0] b;
    logic [7:0] r;
    logic [1:0] oc;
    bit         fin;
    has = 1'b0;
    res = '0;
    b   = it.data_byte;
    pos = fr_pos;
    oc  = OUT_ACCEPTED;
    case (it.mode)
      MODE_DATA: if (fr_phase == PH_LOADING) begin
        if (b == CH_LF && !fr_binary) b = CH_CR;
        if (fr_fill < BLOCK_SIZE) begin
          fr_store[fr_fill] = b;
          fr_xsum = fr_xsum ^ b;
          fr_fill++;
        end
        if (it.end_of_block || fr_fill >= BLOCK_SIZE) begin
          fr_phase = PH_SENDING;
          fr_pos   = 0;
          fr_tries = 4'd0;
        end
      end
      MODE_SLOT: if (fr_phase == PH_SENDING) begin
        has = 1'b1;
        res.kind = KIND_BYTE;
        if (pos == 0) res.tx_byte = CH_STX;
        else if (pos == 1) res.tx_byte = 8'(fr_fill >> 8);
        else if (pos == 2) res.tx_byte = 8'(fr_fill);
        else if (pos < 3 + fr_fill) res.tx_byte = fr_store[pos - 3];
        else if (pos == 3 + fr_fill) res.tx_byte = CH_ETX;
        else res.tx_byte = fr_xsum;
        if (pos >= 4 + fr_fill) begin
          fr_phase = PH_AWAITING;
          fr_pos   = 0;
          if (fr_tries < TRIES_MAX) fr_tries++;
        end else begin
          fr_pos = pos + 1;
        end
      end
      MODE_REPLY: if (fr_phase == PH_AWAITING) begin
        r   = b & REPLY_MASK;
        fin = 1'b1;
        if (r == CH_ACK) oc = OUT_ACCEPTED;
        else if (r == CH_CAN) oc = OUT_CANCELLED;
        else if (r == CH_ESC) oc = OUT_ESCAPED;
        else if (fr_tries >= fr_retry_limit) oc = OUT_EXHAUSTED;
        else begin
          // resend the frame from its first byte
          fin      = 1'b0;
          fr_phase = PH_SENDING;
          fr_pos   = 0;
        end
        if (fin) begin
          fr_fill     = 0;
          fr_xsum     = 8'h00;
          fr_pos      = 0;
          fr_tries    = 4'd0;
          fr_phase    = PH_LOADING;
          has         = 1'b1;
          res.kind    = KIND_REPORT;
          res.outcome = oc;
        end
      end
      default: ;
    endcase
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] pick_reply();
    int unsigned r;
    logic [7:0]  hi;
    r  = $urandom_range(0, 99);
    hi = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h00;
    if (r < 40) return CH_ACK | hi;
    if (r < 50) return CH_CAN | hi;
    if (r < 60) return CH_ESC | hi;
    return 8'($urandom);
  endfunction

  // mostly short blocks, a few full ones and a few that overflow
  function automatic int block_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 24);
    if (r < 97) return BLOCK_SIZE;
    return $urandom_range(BLOCK_SIZE + 1, BLOCK_SIZE + 6);
  endfunction

  task automatic queue_beat(input logic [1:0] m, input logic [7:0] b, input logic eob);
    pend_entry_t e;
    e = '0;
    e.op = OP_BEAT;
    e.beat.mode = m;
    e.beat.data_byte = b;
    e.beat.end_of_block = eob;
    pend.push_back(e);
  endtask

  task automatic queue_cfg(input logic idx, input logic [3:0] val);
    pend_entry_t e;
    e = '0;
    e.op = OP_CFG;
    e.cfg_idx = idx;
    e.cfg_val = val;
    pend.push_back(e);
    if (idx == CFG_RETRY_LIMIT) gen_retry_limit = val;
  endtask

  task automatic queue_drain();
    pend_entry_t e;
    e = '0;
    e.op = OP_DRAIN;
    pend.push_back(e);
  endtask

  // a beat that the framer drops in the given phase
  task automatic queue_noise(input phase_e at);
    logic [1:0] m;
    logic [1:0] live;
    live = (at == PH_LOADING) ? MODE_DATA : (at == PH_SENDING) ? MODE_SLOT : MODE_REPLY;
    m = 2'($urandom_range(0, 3));
    while (m == live) m = 2'($urandom_range(0, 3));
    queue_beat(m, 8'($urandom), 1'($urandom));
  endtask

  // one complete block: load, frame, reply, resend until resolved
  task automatic queue_block(input int n);
    int         flen;
    int         tries;
    bit         open;
    logic [7:0] b;
    logic [7:0] r;
    logic       eob;
    for (int i = 0; i < n; i++) begin
      // past a full block the framer is already sending
      if ($urandom_range(0, 15) == 0)
        queue_noise((i < BLOCK_SIZE) ? PH_LOADING : PH_SENDING);
      b = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom);
      eob = 1'b0;
      if (i == n - 1) eob = (n >= BLOCK_SIZE) ? 1'($urandom) : 1'b1;
      queue_beat(MODE_DATA, b, eob);
    end
    real_items += n;
    flen  = ((n < BLOCK_SIZE) ? n : BLOCK_SIZE) + 5;
    tries = 0;
    open  = 1'b1;
    while (open) begin
      for (int k = 0; k < flen; k++) begin
        if ($urandom_range(0, 15) == 0) queue_noise(PH_SENDING);
        queue_beat(MODE_SLOT, 8'($urandom), 1'($urandom));
      end
      if (tries < TRIES_MAX) tries++;
      if ($urandom_range(0, 5) == 0) queue_noise(PH_AWAITING);
      r = pick_reply();
      queue_beat(MODE_REPLY, r, 1'($urandom));
      real_items += flen + 1;
      if ((r & REPLY_MASK) == CH_ACK || (r & REPLY_MASK) == CH_CAN ||
          (r & REPLY_MASK) == CH_ESC || tries >= gen_retry_limit)
        open = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what, input out_item_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch (%s): expected kind=%0d byte=%02h outcome=%0d,",
                " got kind=%0d byte=%02h outcome=%0d"},
               $time, what, want.kind, want.tx_byte, want.outcome,
               out_item_o.kind, out_item_o.tx_byte, out_item_o.outcome);
  endtask

  // beat driver: pops pending work at the falling edge
  always @(negedge clk_i) begin
    logic       nv;
    in_item_t   ni;
    logic       we;
    logic       widx;
    logic [3:0] wdat;
    if (rst_ni && !run_done) begin
      nv   = in_valid_i;
      ni   = in_item_i;
      we   = 1'b0;
      widx = cfg_idx_i;
      wdat = cfg_data_i;
      if (in_valid_i && beat_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pend.size() == 0) begin
          run_done = 1'b1;
        end else begin
          case (pend[0].op)
            OP_BEAT: begin
              nv = 1'b1;
              ni = pend[0].beat;
              void'(pend.pop_front());
              send_gap = ((cycles / 256) % 3 == 0) ? 0 : gap_len();
            end
            OP_CFG: begin
              we   = 1'b1;
              widx = pend[0].cfg_idx;
              wdat = pend[0].cfg_val;
              void'(pend.pop_front());
            end
            default: begin
              // hold off until every awaited result is in, then let it settle
              if (framer_out_q.size() == 0 && !out_valid_o) begin
                if (settle_cnt == SETTLE_CYCLES) begin
                  settle_cnt = 0;
                  void'(pend.pop_front());
                end else begin
                  settle_cnt++;
                end
              end else begin
                settle_cnt = 0;
              end
            end
          endcase
        end
      end
      in_valid_i <= nv;
      in_item_i  <= ni;
      cfg_we_i   <= we;
      cfg_idx_i  <= widx;
      cfg_data_i <= wdat;
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && beats_taken >= HOLD_AT_BEAT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_gap = ((cycles / 320) % 3 == 1) ? 0 : gap_len();
      end
    end
  end

  // monitor: register writes, result checks, beat prediction, watchdog
  always @(posedge clk_i) begin
    bit        has;
    bit        moved;
    out_item_t want;
    if (rst_ni) begin
      cycles++;
      moved = 1'b0;
      if (cfg_we_i) begin
        moved = 1'b1;
        if (cfg_idx_i == CFG_BINARY_MODE) fr_binary = cfg_data_i[0];
        else fr_retry_limit = cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (framer_out_q.size() == 0) begin
          note_mismatch("no result pending", '0);
        end else begin
          want = framer_out_q.pop_front();
          if (out_item_o.kind !== want.kind || out_item_o.tx_byte !== want.tx_byte ||
              out_item_o.outcome !== want.outcome)
            note_mismatch("field", want);
        end
      end
      beat_taken = in_valid_i && in_ready_o;
      if (beat_taken) begin
        moved = 1'b1;
        beats_taken++;
        framer_predict(in_item_i, has, want);
        if (has) framer_out_q.push_back(want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL block_framer_with_ack_retry");
        $finish;
      end
    end
  end

  initial begin
    // directed: dropped beats in loading, newline turned into CR, byte extremes
    queue_beat(MODE_UNUSED, 8'hff, 1'b1);
    queue_beat(MODE_SLOT, 8'h00, 1'b0);
    queue_beat(MODE_REPLY, CH_ACK, 1'b0);
    queue_beat(MODE_DATA, CH_LF, 1'b0);
    queue_beat(MODE_DATA, 8'hff, 1'b1);
    // data while sending is dropped
    queue_beat(MODE_DATA, 8'h00, 1'b0);
    for (int k = 0; k < 7; k++) queue_beat(MODE_SLOT, 8'h00, 1'b0);
    // negative reply resends, then acknowledge with the top bit set
    queue_beat(MODE_REPLY, 8'h15, 1'b0);
    for (int k = 0; k < 7; k++) queue_beat(MODE_SLOT, 8'hff, 1'b1);
    queue_beat(MODE_REPLY, CH_ACK | 8'h80, 1'b0);
    // single zero byte block, cancelled
    queue_beat(MODE_DATA, 8'h00, 1'b1);
    for (int k = 0; k < 6; k++) queue_beat(MODE_SLOT, 8'h00, 1'b0);
    queue_beat(MODE_REPLY, CH_CAN | 8'h80, 1'b1);

    // random blocks under each register setting
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        queue_drain();
        queue_cfg(CFG_BINARY_MODE, {3'($urandom_range(0, 7)), BIN_PLAN[p]});
        queue_cfg(CFG_RETRY_LIMIT, LIMIT_PLAN[p * 4 +: 4]);
      end
      real_items = 0;
      while (real_items < PHASE_ITEMS) begin
        queue_block(block_len());
        if ($urandom_range(0, 7) == 0) queue_drain();
      end
    end
    queue_drain();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (run_done);
    if (mismatches == 0 && framer_out_q.size() == 0)
      $display("PASS block_framer_with_ack_retry");
    else
      $display("FAIL block_framer_with_ack_retry");
    $finish;
  end

endmodule
